### design/wrpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrpc_pkg
// types and constants shared by the windowed rms / peak classifier
// ----------------------------------------------------------------------------
package wrpc_pkg;

  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned CREST_W  = 13;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CREST_W-1:0] CREST_SAT = 13'd4096;

  // serial step counts of each phase
  localparam int unsigned MUL_STEPS   = SAMPLE_W;
  localparam int unsigned MEAN_STEPS  = SUM_W;
  localparam int unsigned SQRT_STEPS  = PROD_W / 2;
  localparam int unsigned CREST_STEPS = SAMPLE_W + 8;
  localparam int unsigned STEP_W      = 6;

  localparam logic [LIMIT_W-1:0] FAULT_RMS_RESET    = 16'd21299;
  localparam logic [LIMIT_W-1:0] FAULT_PEAK_RESET   = 16'd26214;
  localparam logic [LIMIT_W-1:0] WARN_RMS_RESET     = 16'd14746;
  localparam logic [LIMIT_W-1:0] WARN_PEAK_RESET    = 16'd24576;
  localparam logic [LIMIT_W-1:0] MISSING_RATE_RESET = 16'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAULT_RMS    = 3'd0,
    REG_FAULT_PEAK   = 3'd1,
    REG_WARN_RMS     = 3'd2,
    REG_WARN_PEAK    = 3'd3,
    REG_MISSING_RATE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_NORMAL   = 2'd0,
    CLS_WARNING  = 2'd1,
    CLS_FAULT    = 2'd2,
    CLS_DEGRADED = 2'd3
  } event_class_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       window_end;
    logic [15:0]                missing_rate;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]        rms_value;
    logic [15:0]        peak_value;
    logic [CREST_W-1:0] crest_ratio;
    logic               complete_flag;
    event_class_t       event_class;
  } out_beat_t;

endpackage

### design/window_rms_peak_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_rms_peak_classifier_unit
// windowed rms, peak and crest factor with event classification
// ----------------------------------------------------------------------------
//  channel | signals                              | direction | handshake
//  --------+--------------------------------------+-----------+-----------------
//  in      | in_valid, in_stall, in_data          | sink      | valid & !stall
//  out     | out_valid, out_stall, out_data       | source    | valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | sink      | valid & ready
//
//  a sample beat runs the accept in idle, the bit-serial squarer and the
//  accumulate state adding into the saturating sum
//  the closing beat adds the serial mean division, the two-bit-per-cycle
//  square root, the crest division (skipped when rms is zero) and the emit
//  state, which loads the output register once it is free or being read
//  synchronous reset clears the limits to their defaults and the window
//  a waiting result does not block sample intake; only a second result
//  that finds the output register still full holds the unit
// ----------------------------------------------------------------------------
module window_rms_peak_classifier_unit
  import wrpc_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_MUL       = 7'b0000010,
    ST_ACC       = 7'b0000100,
    ST_DIV_MEAN  = 7'b0001000,
    ST_SQRT      = 7'b0010000,
    ST_DIV_CREST = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_t;

  state_t state;
  logic [STEP_W-1:0] step;

  // limits
  logic [LIMIT_W-1:0] fault_rms_limit;
  logic [LIMIT_W-1:0] fault_peak_limit;
  logic [LIMIT_W-1:0] warn_rms_limit;
  logic [LIMIT_W-1:0] warn_peak_limit;
  logic [LIMIT_W-1:0] missing_rate_limit;

  // window accumulators
  logic [SUM_W-1:0]    square_sum;
  logic [SAMPLE_W-1:0] peak_so_far;
  logic [CNT_W-1:0]    sample_count;
  logic                is_last;
  logic [15:0]         missing;

  // squarer
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] mul_bits;
  logic [PROD_W-1:0]   prod;

  // shared restoring divider
  logic [SUM_W-1:0]    quo;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] divisor;

  // square root
  logic [PROD_W-1:0]         sq_src;
  logic [SAMPLE_W+1:0]       sq_rem;
  logic [SAMPLE_W-1:0]       root;

  logic                in_accept;
  logic                emit_go;
  logic [SAMPLE_W-1:0] in_mag;
  logic [CNT_W-1:0]    count_inc;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W:0]   div_sh;
  logic                div_ge;
  logic [SAMPLE_W-1:0] rem_next;
  logic [SAMPLE_W+3:0] sq_sh;
  logic [SAMPLE_W+3:0] sq_trial;
  logic                sq_ge;
  logic [CREST_W-1:0]  crest_next;
  logic                complete_next;
  event_class_t        class_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign emit_go   = (state == ST_EMIT) && (!out_valid || !out_stall);

  // two's complement magnitude, -32768 maps to 0x8000
  assign in_mag    = in_data.sample[SAMPLE_W-1] ?
                     (~in_data.sample + SAMPLE_W'(1)) : in_data.sample;
  assign count_inc = sample_count + CNT_W'(1);

  // saturating accumulate
  assign sum_wide = {1'b0, square_sum} + (SUM_W + 1)'(prod);
  assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  // one quotient bit per cycle
  assign div_sh   = {rem, quo[SUM_W-1]};
  assign div_ge   = div_sh >= {1'b0, divisor};
  assign rem_next = div_ge ? SAMPLE_W'(div_sh - {1'b0, divisor}) : div_sh[SAMPLE_W-1:0];

  // one root bit per cycle, two radicand bits in
  assign sq_sh    = {sq_rem, sq_src[PROD_W-1 -: 2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  always_comb begin
    if (root == '0) begin
      crest_next = '0;
    end else if (quo[CREST_STEPS-1:0] > CREST_STEPS'(CREST_SAT)) begin
      crest_next = CREST_SAT;
    end else begin
      crest_next = quo[CREST_W-1:0];
    end
    complete_next = (missing <= missing_rate_limit);
    if (!complete_next) begin
      class_next = CLS_DEGRADED;
    end else if (root > fault_rms_limit && peak_so_far > fault_peak_limit) begin
      class_next = CLS_FAULT;
    end else if (root > warn_rms_limit || peak_so_far > warn_peak_limit) begin
      class_next = CLS_WARNING;
    end else begin
      class_next = CLS_NORMAL;
    end
  end

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_rms_limit    <= FAULT_RMS_RESET;
      fault_peak_limit   <= FAULT_PEAK_RESET;
      warn_rms_limit     <= WARN_RMS_RESET;
      warn_peak_limit    <= WARN_PEAK_RESET;
      missing_rate_limit <= MISSING_RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FAULT_RMS:    fault_rms_limit    <= cfg_data;
        REG_FAULT_PEAK:   fault_peak_limit   <= cfg_data;
        REG_WARN_RMS:     warn_rms_limit     <= cfg_data;
        REG_WARN_PEAK:    warn_peak_limit    <= cfg_data;
        REG_MISSING_RATE: missing_rate_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register, held while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      square_sum   <= '0;
      peak_so_far  <= '0;
      sample_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            // peak and count settle now, the square follows serially
            if (in_mag > peak_so_far) begin
              peak_so_far <= in_mag;
            end
            sample_count <= count_inc;
            step         <= STEP_W'(MUL_STEPS - 1);
            state        <= ST_MUL;
          end
        end
        ST_MUL: begin
          step <= step - STEP_W'(1);
          if (step == '0) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          square_sum <= sum_next;
          if (is_last) begin
            step  <= STEP_W'(MEAN_STEPS - 1);
            state <= ST_DIV_MEAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV_MEAN: begin
          if (step == '0) begin
            step  <= STEP_W'(SQRT_STEPS - 1);
            state <= ST_SQRT;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_SQRT: begin
          if (step == '0) begin
            // zero rms has no crest ratio to work out
            if ({root[SAMPLE_W-2:0], sq_ge} == '0) begin
              state <= ST_EMIT;
            end else begin
              step  <= STEP_W'(CREST_STEPS - 1);
              state <= ST_DIV_CREST;
            end
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_DIV_CREST: begin
          step <= step - STEP_W'(1);
          if (step == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            square_sum   <= '0;
            peak_so_far  <= '0;
            sample_count <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // serial datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          mag      <= in_mag;
          mul_bits <= in_mag;
          prod     <= '0;
          is_last  <= in_data.window_end || (count_inc >= CNT_W'(MAX_WINDOW));
          missing  <= in_data.missing_rate;
        end
      end
      ST_MUL: begin
        // msb-first shift and add
        prod     <= {prod[PROD_W-2:0], 1'b0} +
                    (mul_bits[SAMPLE_W-1] ? PROD_W'(mag) : '0);
        mul_bits <= {mul_bits[SAMPLE_W-2:0], 1'b0};
      end
      ST_ACC: begin
        quo     <= sum_next;
        rem     <= '0;
        divisor <= SAMPLE_W'(sample_count);
      end
      ST_DIV_MEAN: begin
        quo <= {quo[SUM_W-2:0], div_ge};
        rem <= rem_next;
        if (step == '0) begin
          // the mean never exceeds a single full-scale square
          sq_src <= {quo[PROD_W-2:0], div_ge};
          sq_rem <= '0;
          root   <= '0;
        end
      end
      ST_SQRT: begin
        sq_src <= {sq_src[PROD_W-3:0], 2'b00};
        sq_rem <= sq_ge ? (SAMPLE_W + 2)'(sq_sh - sq_trial) : sq_sh[SAMPLE_W+1:0];
        root   <= {root[SAMPLE_W-2:0], sq_ge};
        if (step == '0) begin
          // peak * 256 placed at the top of the dividend
          quo     <= {peak_so_far, 8'd0, (SUM_W - CREST_STEPS)'(0)};
          rem     <= '0;
          divisor <= {root[SAMPLE_W-2:0], sq_ge};
        end
      end
      ST_DIV_CREST: begin
        quo <= {quo[SUM_W-2:0], div_ge};
        rem <= rem_next;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_data.rms_value     <= root;
          out_data.peak_value    <= peak_so_far;
          out_data.crest_ratio   <= crest_next;
          out_data.complete_flag <= complete_next;
          out_data.event_class   <= class_next;
        end
      end
      default: ;
    endcase
  end

  // an accepted sample always starts the squarer
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_MUL))
    else $error("accepted sample did not start the squarer");

  // a new result only appears from the emit state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit");

  // the window is cleared once its result is loaded
  assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (sample_count == '0) && (square_sum == '0) && out_valid)
    else $error("window not cleared after result");

endmodule

### bench/window_rms_peak_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_rms_peak_classifier_unit_tb
// self-checking bench for the windowed rms / peak classifier: sample beats
// go in with random gaps and output stalls, a built-in predictor works out
// each window summary and every output beat is compared field by field
// ----------------------------------------------------------------------------
module window_rms_peak_classifier_unit_tb;
  import wrpc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned WINDOW_MAX     = 256;
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned RECONFIG_EVERY = 250;
  // a closing sample also runs both divisions and the root; leave margin
  localparam int unsigned SETTLE_CYCLES  = 150;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned MAX_REPORTS    = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  // predictor copy of the limits and of the window accumulators
  logic [LIMIT_W-1:0] lim_fault_rms;
  logic [LIMIT_W-1:0] lim_fault_peak;
  logic [LIMIT_W-1:0] lim_warn_rms;
  logic [LIMIT_W-1:0] lim_warn_peak;
  logic [LIMIT_W-1:0] lim_missing;
  logic [SUM_W-1:0]   acc_square_sum;
  logic [15:0]        acc_peak;
  logic [CREST_W-1:0] acc_count;

  out_beat_t   pending_summaries[$];
  int unsigned mismatches = 0;
  int unsigned summaries_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_hold = 0;
  bit          calm = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  window_rms_peak_classifier_unit #(
    .MAX_WINDOW(WINDOW_MAX)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  task automatic reset_predictor();
    lim_fault_rms  = FAULT_RMS_RESET;
    lim_fault_peak = FAULT_PEAK_RESET;
    lim_warn_rms   = WARN_RMS_RESET;
    lim_warn_peak  = WARN_PEAK_RESET;
    lim_missing    = MISSING_RATE_RESET;
    acc_square_sum = '0;
    acc_peak       = '0;
    acc_count      = '0;
  endtask

  // floor square root, built one result bit at a time from the top
  function automatic logic [15:0] floor_root(input logic [SUM_W-1:0] v);
    logic [31:0] root;
    logic [63:0] cand;
    root = '0;
    for (int bit_pos = 20; bit_pos >= 0; bit_pos--) begin
      cand = {32'd0, root | (32'd1 << bit_pos)};
      if (cand * cand <= {24'd0, v}) root = cand[31:0];
    end
    return root[15:0];
  endfunction

  // folds one sample into the window; returns 1 with the summary when it closes
  function automatic bit fold_sample(input in_beat_t b, output out_beat_t summary);
    logic [15:0]      raw;
    logic [16:0]      mag;
    logic [SUM_W:0]   wide_sum;
    logic [SUM_W:0]   square;
    logic [SUM_W-1:0] mean_sq;
    logic [15:0]      rms;
    logic [31:0]      ratio;
    logic             complete;
    summary = '0;
    raw = b.sample;
    mag = raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
    square = (SUM_W + 1)'(mag) * (SUM_W + 1)'(mag);
    wide_sum = {1'b0, acc_square_sum} + square;
    // saturating sum, only reachable with very long windows
    acc_square_sum = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
    if (mag[15:0] > acc_peak) acc_peak = mag[15:0];
    acc_count = acc_count + CREST_W'(1);
    if (!b.window_end && acc_count < CREST_W'(WINDOW_MAX)) return 1'b0;

    mean_sq = (acc_count != 0) ? acc_square_sum / SUM_W'(acc_count) : '0;
    rms = floor_root(mean_sq);
    if (rms == 0) begin
      summary.crest_ratio = '0;
    end else begin
      ratio = ({16'd0, acc_peak} << 8) / {16'd0, rms};
      summary.crest_ratio = (ratio > 32'd4096) ? CREST_SAT : ratio[CREST_W-1:0];
    end
    complete = (b.missing_rate <= lim_missing);
    summary.rms_value     = rms;
    summary.peak_value    = acc_peak;
    summary.complete_flag = complete;
    if (!complete) begin
      summary.event_class = CLS_DEGRADED;
    end else if (rms > lim_fault_rms && acc_peak > lim_fault_peak) begin
      summary.event_class = CLS_FAULT;
    end else if (rms > lim_warn_rms || acc_peak > lim_warn_peak) begin
      summary.event_class = CLS_WARNING;
    end else begin
      summary.event_class = CLS_NORMAL;
    end
    acc_square_sum = '0;
    acc_peak       = '0;
    acc_count      = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // idling
  // --------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 98) return $urandom_range(5, 30);
    return $urandom_range(31, 150);
  endfunction

  // output back-pressure held in bursts of random length
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < 30);
      stall_hold <= pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one sample beat, after a random gap; valid stays high for a following beat
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last,
                             input logic [15:0] miss);
    in_beat_t    b;
    out_beat_t   summary;
    int unsigned gap;
    b.sample       = s;
    b.window_end   = last;
    b.missing_rate = miss;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (fold_sample(b, summary)) pending_summaries.push_back(summary);
  endtask

  // one register write beat; valid is left high for a following write
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FAULT_RMS:    lim_fault_rms  = val;
      REG_FAULT_PEAK:   lim_fault_peak = val;
      REG_WARN_RMS:     lim_warn_rms   = val;
      REG_WARN_PEAK:    lim_warn_peak  = val;
      REG_MISSING_RATE: lim_missing    = val;
      default: ;
    endcase
  endtask

  // called in the step of the last accepted beat; drops both valids and lets the inputs go idle
  task automatic park_inputs();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every summary is out and the unit has gone quiet
  task automatic drain_results();
    park_inputs();
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("mismatch in summary %0d, %s: expected %0d, got %0d",
                 summaries_seen, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_summaries
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_summaries.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("summary beat with none expected: rms %0d peak %0d class %0d",
                   out_data.rms_value, out_data.peak_value, out_data.event_class);
        mismatches++;
      end else begin
        want = pending_summaries.pop_front();
        check_field("rms_value", 32'(want.rms_value), 32'(out_data.rms_value));
        check_field("peak_value", 32'(want.peak_value), 32'(out_data.peak_value));
        check_field("crest_ratio", 32'(want.crest_ratio), 32'(out_data.crest_ratio));
        check_field("complete_flag", 32'(want.complete_flag),
                    32'(out_data.complete_flag));
        check_field("event_class", 32'(want.event_class), 32'(out_data.event_class));
      end
      summaries_seen++;
    end
  end

  // no beat on any channel for too long means the unit has hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned amp,
                                                            input int unsigned style);
    int          v;
    int unsigned mode;
    mode = (style == 3) ? $urandom_range(0, 2) : style;
    case (mode)
      0: return SAMPLE_W'($urandom);
      1: begin
        // spread around the window's own amplitude
        v = int'($urandom_range(0, 2 * amp)) - int'(amp);
        if (v > 32767) v = 32767;
        return v[SAMPLE_W-1:0];
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
    endcase
  endfunction

  // missing rates cluster on the limit so both sides of it are hit
  function automatic logic [15:0] pick_missing();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return lim_missing;
      2: return (lim_missing == 16'hFFFF) ? lim_missing : lim_missing + 16'd1;
      default: return 16'($urandom_range(0, lim_missing));
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd32768;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic reconfigure_random();
    logic [LIMIT_W-1:0] miss_lim;
    drain_results();
    case ($urandom_range(0, 9))
      0: miss_lim = 16'd0;
      1: miss_lim = 16'hFFFF;
      default: miss_lim = 16'($urandom_range(0, 65535));
    endcase
    write_limit(REG_FAULT_RMS, pick_threshold());
    write_limit(REG_FAULT_PEAK, pick_threshold());
    write_limit(REG_WARN_RMS, pick_threshold());
    write_limit(REG_WARN_PEAK, pick_threshold());
    write_limit(REG_MISSING_RATE, miss_lim);
    park_inputs();
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // short windows under the reset limits, one for each class and corner
  task automatic test_directed_windows();
    // all-zero window: rms of zero gives a crest ratio of zero
    send_sample(16'sh0000, 1'b1, 16'd0);
    // most negative sample: peak of full scale, fault
    send_sample(16'sh8000, 1'b1, 16'd0);
    // largest positive sample with everything missing: degraded
    send_sample(16'sh7FFF, 1'b1, 16'hFFFF);
    // rms over the fault level but peak under it: warning only
    send_sample(16'sd22000, 1'b1, 16'd100);
    // peak alone over the warning level
    send_sample(16'sd25000, 1'b0, 16'd0);
    send_sample(16'sh0000, 1'b0, 16'd0);
    send_sample(16'sh0000, 1'b0, 16'd0);
    send_sample(16'sh0000, 1'b1, 16'd0);
    // quiet signal: normal
    send_sample(16'sd1000, 1'b0, 16'd0);
    send_sample(-16'sd1000, 1'b1, 16'd0);
    // missing rate exactly on the limit still counts as complete
    send_sample(16'sd2, 1'b0, 16'd0);
    send_sample(16'sd1, 1'b1, MISSING_RATE_RESET);
    // mean floors to zero under a nonzero peak, one over the limit
    for (int n = 0; n < 10; n++)
      send_sample((n == 0) ? 16'sd3 : 16'sd0, n == 9, MISSING_RATE_RESET + 16'd1);
    park_inputs();
  endtask

  task automatic test_limit_registers();
    drain_results();
    // zero thresholds: any nonzero rms is a fault, only zero missing is complete
    write_limit(REG_FAULT_RMS, 16'd0);
    write_limit(REG_FAULT_PEAK, 16'd0);
    write_limit(REG_WARN_RMS, 16'd0);
    write_limit(REG_WARN_PEAK, 16'd0);
    write_limit(REG_MISSING_RATE, 16'd0);
    park_inputs();
    send_sample(16'sh0000, 1'b1, 16'd0);
    send_sample(16'sh0001, 1'b1, 16'd0);
    send_sample(16'sh8000, 1'b1, 16'd1);
    drain_results();

    // full-scale thresholds: nothing can exceed them, every rate is complete
    write_limit(REG_FAULT_RMS, 16'd32768);
    write_limit(REG_FAULT_PEAK, 16'd32768);
    write_limit(REG_WARN_RMS, 16'd32768);
    write_limit(REG_WARN_PEAK, 16'd32768);
    write_limit(REG_MISSING_RATE, 16'hFFFF);
    park_inputs();
    send_sample(16'sh8000, 1'b1, 16'hFFFF);
    send_sample(16'sh7FFF, 1'b1, 16'($urandom_range(0, 65535)));
    drain_results();

    // indexes past the last register must leave every limit alone
    for (int idx = int'(REG_MISSING_RATE) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_limit(idx[CFG_IDX_W-1:0], 16'($urandom_range(0, 65535)));
    park_inputs();
    send_sample(16'sh8000, 1'b1, 16'hFFFF);
    send_sample(16'sh0001, 1'b1, 16'd0);
    drain_results();

    // back to the reset limits
    write_limit(REG_FAULT_RMS, FAULT_RMS_RESET);
    write_limit(REG_FAULT_PEAK, FAULT_PEAK_RESET);
    write_limit(REG_WARN_RMS, WARN_RMS_RESET);
    write_limit(REG_WARN_PEAK, WARN_PEAK_RESET);
    write_limit(REG_MISSING_RATE, MISSING_RATE_RESET);
    park_inputs();
  endtask

  task automatic test_full_window();
    // no window end at all: the sample that fills the window closes it, and a
    // lone near-full-scale spike among zeros saturates the crest ratio
    for (int n = 0; n < WINDOW_MAX; n++)
      send_sample((n == 37) ? 16'sh7FFF : 16'sh0000, 1'b0,
                  16'($urandom_range(0, 65535)));
    // window end on the very sample that fills it: still one summary
    for (int n = 0; n < WINDOW_MAX; n++)
      send_sample(pick_sample(20000, 3), n == WINDOW_MAX - 1, pick_missing());
    // one short of full, closed by the window end
    for (int n = 0; n < WINDOW_MAX - 1; n++)
      send_sample(pick_sample(5000, 1), n == WINDOW_MAX - 2, pick_missing());
    park_inputs();
  endtask

  task automatic test_random_windows(input int unsigned budget);
    int unsigned sent;
    int unsigned since_cfg;
    int unsigned len;
    int unsigned amp;
    int unsigned style;
    logic [15:0] miss;
    sent = 0;
    since_cfg = 0;
    while (sent < budget) begin
      if (since_cfg >= RECONFIG_EVERY) begin
        reconfigure_random();
        since_cfg = 0;
      end
      // now and then a stretch with no idling on either side
      calm = ($urandom_range(0, 9) == 0);
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(17, WINDOW_MAX)
                                         : $urandom_range(1, 16);
      amp   = $urandom_range(1, 32768);
      style = $urandom_range(0, 3);
      miss  = pick_missing();
      for (int n = 0; n < len; n++)
        send_sample(pick_sample(amp, style), n == len - 1,
                    (n == len - 1) ? miss : 16'($urandom_range(0, 65535)));
      sent += len;
      since_cfg += len;
    end
    calm = 1'b0;
    park_inputs();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_windows();
    test_limit_registers();
    test_full_window();
    test_random_windows(RANDOM_ITEMS);
    drain_results();
    if (mismatches == 0 && pending_summaries.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
design/wrpc_pkg.sv
design/window_rms_peak_classifier_unit.sv
bench/window_rms_peak_classifier_unit_tb.sv
